// File: sv/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and the sine kernel of the space vector PWM block.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b1;

    localparam logic [15:0] SUPPLY_RESET = 16'd12000;
    localparam logic [15:0] PERIOD_RESET = 16'd4800;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [16:0] SQ3_Q16 = 17'd113512;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    localparam logic [2:0] SIGN_TO_SECTOR [8] = '{
        SECTOR_2, SECTOR_2, SECTOR_6, SECTOR_1,
        SECTOR_4, SECTOR_3, SECTOR_5, SECTOR_2
    };

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] K1 = 64'd1686629713;
    localparam logic [63:0] K3 = 64'd693598671;
    localparam logic [63:0] K5 = 64'd85569306;
    localparam logic [63:0] K7 = 64'd5026995;
    localparam logic [63:0] K9 = 64'd172272;

    typedef struct packed {
        logic signed [15:0] uq;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
    } t_mid;

    // Q15 sine of a turn fraction in Q32, odd polynomial on the quadrant
    function automatic logic signed [16:0] sine_q15(input logic [63:0] t);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        q  = t[31:30];
        r  = {34'd0, t[29:0]};
        u  = q[0] ? (Q30_ONE - r) : r;
        u2 = (u * u) >> 30;
        p  = K7 - ((u2 * K9) >> 30);
        p  = K5 - ((u2 * p) >> 30);
        p  = K3 - ((u2 * p) >> 30);
        p  = K1 - ((u2 * p) >> 30);
        s  = (u * p) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768) begin
            s = 64'd32768;
        end
        return q[1] ? -17'(s) : 17'(s);
    endfunction

endpackage

// File: sv/svpwm_if.sv
// ----------------------------------------------------------------------------
// svpwm channel interfaces
// Valid/ready channels for commands, internal trig items and compare results.
// ----------------------------------------------------------------------------
interface svpwm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] uq;
    logic        [15:0] angle;

    modport source (output valid, output uq, output angle, input ready);
    modport sink   (input valid, input uq, input angle, output ready);
endinterface

interface svpwm_mid_if;
    import svpwm_pkg::*;
    logic valid;
    logic ready;
    t_mid data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svpwm_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] cmp_a;
    logic [14:0] cmp_b;
    logic [14:0] cmp_c;
    logic [2:0]  sector;

    modport source (output valid, output cmp_a, output cmp_b, output cmp_c,
                    output sector, input ready);
    modport sink   (input valid, input cmp_a, input cmp_b, input cmp_c,
                    input sector, output ready);
endinterface

// File: sv/svpwm_div.sv
// ----------------------------------------------------------------------------
// svpwm_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Requires the numerator below divisor times two to the quotient width.
// ----------------------------------------------------------------------------
module svpwm_div #(
    parameter int DW = 16,
    parameter int QW = 20,
    parameter int TW = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [TW-1:0]    i_tag,
    output logic             o_vld,
    output logic [QW-1:0]    o_quo,
    output logic [TW-1:0]    o_tag
);
    logic [QW-1:0] r_vld;
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [DW-1:0] r_den [QW];
    logic [TW-1:0] r_tag [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_low [QW];
    logic [DW-1:0] p_rem [QW];
    logic [QW-1:0] p_low [QW];
    logic [DW-1:0] p_den [QW];

    always_comb begin
        logic [DW:0] trial;
        logic        ge;
        p_rem[0] = i_num[DW+QW-1:QW];
        p_low[0] = i_num[QW-1:0];
        p_den[0] = i_den;
        for (int k = 1; k < QW; k++) begin
            p_rem[k] = r_rem[k-1];
            p_low[k] = r_low[k-1];
            p_den[k] = r_den[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            trial    = {p_rem[k], p_low[k][QW-1]};
            ge       = trial >= {1'b0, p_den[k]};
            n_rem[k] = ge ? DW'(trial - {1'b0, p_den[k]}) : trial[DW-1:0];
            n_low[k] = {p_low[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < QW; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_den[k] <= p_den[k];
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_low[QW-1];
    assign o_tag = r_tag[QW-1];
endmodule

// File: sv/svpwm_front.sv
// ----------------------------------------------------------------------------
// svpwm_front
// Accepts commands, clamps the voltage and looks up sine and cosine.
// ----------------------------------------------------------------------------
module svpwm_front #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_supply,
    svpwm_in_if.sink    i_in,
    svpwm_mid_if.source o_mid
);
    import svpwm_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = 16 + IW + 1;
    localparam logic [15:0] AMASK =
        (ANGLE_BITS >= 16) ? 16'hFFFF : 16'((1 << ANGLE_BITS) - 1);

    typedef logic [33:0] t_tab [SINE_TABLE_DEPTH];

    function automatic t_tab build_tab();
        t_tab        tb;
        logic [63:0] t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t     = (64'(i) << 32) / SINE_TABLE_DEPTH;
            tb[i] = {sine_q15(t), sine_q15(t + Q30_ONE)};
        end
        return tb;
    endfunction

    localparam t_tab TAB = build_tab();

    logic               r_vld;
    logic signed [15:0] r_uq;
    logic        [33:0] r_sc;
    logic [PW-1:0]      prod;
    logic [IW-1:0]      idx;
    logic signed [16:0] uqx;
    logic signed [16:0] hp;
    logic signed [16:0] uqc;
    logic               acc;

    assign prod = PW'(i_in.angle & AMASK) * PW'(SINE_TABLE_DEPTH);
    assign idx  = IW'(prod >> ANGLE_BITS);
    assign uqx  = {i_in.uq[15], i_in.uq};
    assign hp   = {2'b00, i_supply[15:1]};

    always_comb begin
        priority if (uqx > hp) begin
            uqc = hp;
        end else if (uqx < -hp) begin
            uqc = -hp;
        end else begin
            uqc = uqx;
        end
    end

    assign i_in.ready = !r_vld || o_mid.ready;
    assign acc        = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= 1'b1;
        end else if (o_mid.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_uq <= uqc[15:0];
            r_sc <= TAB[idx];
        end
    end

    assign o_mid.valid   = r_vld;
    assign o_mid.data.uq = r_uq;
    assign o_mid.data.sn = r_sc[33:17];
    assign o_mid.data.cs = r_sc[16:0];
endmodule

// File: sv/svpwm_queue.sv
// ----------------------------------------------------------------------------
// svpwm_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module svpwm_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svpwm_mid_if.sink   i_mid,
    svpwm_mid_if.source o_mid
);
    import svpwm_pkg::*;

    t_mid                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push;
    logic                pop;

    assign i_mid.ready = r_cnt < (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_mid.valid = r_cnt != '0;
    assign o_mid.data  = r_mem[r_rp];
    assign push        = i_mid.valid && i_mid.ready;
    assign pop         = o_mid.valid && o_mid.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_mid.data;
        end
    end
endmodule

// File: sv/svpwm_back.sv
// ----------------------------------------------------------------------------
// svpwm_back
// Inverse Park, sector, dwell times, rescale and phase compare values.
// ----------------------------------------------------------------------------
module svpwm_back (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_supply,
    input  logic [15:0] i_period,
    svpwm_mid_if.sink   i_mid,
    svpwm_out_if.source o_out
);
    import svpwm_pkg::*;

    localparam int DQW = 20;

    logic        en;
    logic [19:0] per;
    logic [15:0] vse;
    logic [6:0]  r_va;
    logic [1:0]  r_vb;

    logic signed [32:0] pa;
    logic signed [32:0] pb;
    logic signed [31:0] r1_ua;
    logic signed [31:0] r1_ub;
    logic signed [48:0] r2_a;
    logic signed [31:0] r2_ub;
    logic signed [50:0] ax;
    logic signed [50:0] ubs;
    logic signed [50:0] w1;
    logic signed [50:0] w2;
    logic signed [50:0] w3;
    logic [2:0]         sbits;
    logic [2:0]         sec3;
    logic signed [50:0] e1;
    logic signed [50:0] e2;
    logic signed [50:0] r3_e1;
    logic signed [50:0] r3_e2;
    logic [2:0]         r3_sec;
    logic [26:0]        r4_m1;
    logic [26:0]        r4_m2;
    logic [2:0]         r4_sec;
    logic [43:0]        r5_k1;
    logic [43:0]        r5_k2;
    logic [2:0]         r5_sec;
    logic [59:0]        r6_n1;
    logic [59:0]        r6_n2;
    logic [35:0]        r6_lim;
    logic [2:0]         r6_sec;
    logic               sat1;
    logic               sat2;
    logic [35:0]        r7_num1;
    logic [35:0]        r7_num2;
    logic [3:0]         r7_tag1;
    logic               r7_sat2;

    logic               d1a_vld;
    logic               d1b_vld;
    logic [DQW-1:0]     d1a_quo;
    logic [DQW-1:0]     d1b_quo;
    logic [3:0]         d1a_tag;
    logic               d1b_tag;

    logic [19:0]        t1;
    logic [19:0]        t2;
    logic [20:0]        tsum;
    logic [19:0]        r8_t1;
    logic [19:0]        r8_t2;
    logic [20:0]        r8_sum;
    logic               r8_resc;
    logic [2:0]         r8_sec;
    logic [40:0]        r9_p1;
    logic [40:0]        r9_p2;
    logic [20:0]        r9_sum;
    logic [23:0]        r9_tag1;
    logic [19:0]        r9_t2;

    logic               d2a_vld;
    logic               d2b_vld;
    logic [DQW-1:0]     d2a_quo;
    logic [DQW-1:0]     d2b_quo;
    logic [23:0]        d2a_tag;
    logic [19:0]        d2b_tag;

    logic               resc;
    logic [2:0]         sec_f;
    logic [19:0]        t1f;
    logic [19:0]        t2f;
    logic [20:0]        rest;
    logic [19:0]        v1;
    logic [19:0]        v2;
    logic [19:0]        v3;
    logic [19:0]        ta;
    logic [19:0]        tb;
    logic [19:0]        tc;
    logic               r_ov;
    logic [14:0]        r_ca;
    logic [14:0]        r_cb;
    logic [14:0]        r_cc;
    logic [2:0]         r_sec;

    assign en          = !r_ov || o_out.ready;
    assign i_mid.ready = en;
    assign per         = {i_period, 4'b0000};
    assign vse         = (i_supply == 16'd0) ? 16'd1 : i_supply;

    // inverse Park and doubled references
    assign pa    = i_mid.data.uq * i_mid.data.sn;
    assign pb    = i_mid.data.uq * i_mid.data.cs;
    assign ax    = {{2{r2_a[48]}}, r2_a};
    assign ubs   = {{3{r2_ub[31]}}, r2_ub, 16'd0};
    assign w1    = {{2{r2_ub[31]}}, r2_ub, 17'd0};
    assign w2    = ax - ubs;
    assign w3    = -(ax + ubs);
    assign sbits = {!w3[50] && (w3 != '0), !w2[50] && (w2 != '0),
                    !w1[50] && (w1 != '0)};
    assign sec3  = SIGN_TO_SECTOR[sbits];

    always_comb begin
        unique case (sec3)
            SECTOR_1: begin e1 = w2;  e2 = w1;  end
            SECTOR_2: begin e1 = -w2; e2 = -w3; end
            SECTOR_3: begin e1 = w1;  e2 = w3;  end
            SECTOR_4: begin e1 = -w1; e2 = -w2; end
            SECTOR_5: begin e1 = w3;  e2 = w2;  end
            default:  begin e1 = -w3; e2 = -w1; end
        endcase
    end

    assign sat1 = r6_n1[59:21] >= {3'b000, r6_lim};
    assign sat2 = r6_n2[59:21] >= {3'b000, r6_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
        end else if (en) begin
            r_va <= {r_va[5:0], i_mid.valid};
            r_vb <= {r_vb[0], d1a_vld && d1b_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ua   <= 32'(-pa);
            r1_ub   <= 32'(pb);
            r2_a    <= 49'($signed({1'b0, SQ3_Q16}) * r1_ua);
            r2_ub   <= r1_ub;
            r3_e1   <= e1;
            r3_e2   <= e2;
            r3_sec  <= sec3;
            r4_m1   <= (!r3_e1[50] && (r3_e1 != '0)) ? r3_e1[49:23] : '0;
            r4_m2   <= (!r3_e2[50] && (r3_e2 != '0)) ? r3_e2[49:23] : '0;
            r4_sec  <= r3_sec;
            r5_k1   <= 44'(r4_m1) * 44'(SQ3_Q16);
            r5_k2   <= 44'(r4_m2) * 44'(SQ3_Q16);
            r5_sec  <= r4_sec;
            r6_n1   <= 60'(r5_k1) * 60'(i_period);
            r6_n2   <= 60'(r5_k2) * 60'(i_period);
            r6_lim  <= 36'(per) * 36'(vse);
            r6_sec  <= r5_sec;
            r7_num1 <= sat1 ? '0 : r6_n1[56:21];
            r7_num2 <= sat2 ? '0 : r6_n2[56:21];
            r7_tag1 <= {sat1, r6_sec};
            r7_sat2 <= sat2;
        end
    end

    svpwm_div #(.DW(16), .QW(DQW), .TW(4)) u_div1a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_va[6]),
        .i_num(r7_num1), .i_den(vse), .i_tag(r7_tag1),
        .o_vld(d1a_vld), .o_quo(d1a_quo), .o_tag(d1a_tag)
    );

    svpwm_div #(.DW(16), .QW(DQW), .TW(1)) u_div1b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_va[6]),
        .i_num(r7_num2), .i_den(vse), .i_tag(r7_sat2),
        .o_vld(d1b_vld), .o_quo(d1b_quo), .o_tag(d1b_tag)
    );

    assign t1   = d1a_tag[3] ? per : d1a_quo;
    assign t2   = d1b_tag ? per : d1b_quo;
    assign tsum = {1'b0, t1} + {1'b0, t2};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_t1   <= t1;
            r8_t2   <= t2;
            r8_sum  <= tsum;
            r8_resc <= tsum > {1'b0, per};
            r8_sec  <= d1a_tag[2:0];
            r9_p1   <= r8_resc ? {1'b0, 40'(r8_t1) * 40'(per)} : '0;
            r9_p2   <= r8_resc ? {1'b0, 40'(r8_t2) * 40'(per)} : '0;
            r9_sum  <= r8_sum;
            r9_tag1 <= {r8_resc, r8_sec, r8_t1};
            r9_t2   <= r8_t2;
        end
    end

    svpwm_div #(.DW(21), .QW(DQW), .TW(24)) u_div2a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_vb[1]),
        .i_num(r9_p1), .i_den(r9_sum), .i_tag(r9_tag1),
        .o_vld(d2a_vld), .o_quo(d2a_quo), .o_tag(d2a_tag)
    );

    svpwm_div #(.DW(21), .QW(DQW), .TW(20)) u_div2b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_vb[1]),
        .i_num(r9_p2), .i_den(r9_sum), .i_tag(r9_t2),
        .o_vld(d2b_vld), .o_quo(d2b_quo), .o_tag(d2b_tag)
    );

    // centre-aligned phase times
    assign resc  = d2a_tag[23];
    assign sec_f = d2a_tag[22:20];
    assign t1f   = resc ? d2a_quo : d2a_tag[19:0];
    assign t2f   = resc ? d2b_quo : d2b_tag;
    assign rest  = {1'b0, per} - {1'b0, t1f} - {1'b0, t2f};
    assign v3    = rest[20:1];
    assign v2    = t2f + v3;
    assign v1    = t1f + v2;

    always_comb begin
        unique case (sec_f)
            SECTOR_1: begin ta = v1; tb = v2; tc = v3; end
            SECTOR_2: begin ta = v2; tb = v1; tc = v3; end
            SECTOR_3: begin ta = v3; tb = v1; tc = v2; end
            SECTOR_4: begin ta = v3; tb = v2; tc = v1; end
            SECTOR_5: begin ta = v2; tb = v3; tc = v1; end
            default:  begin ta = v1; tb = v3; tc = v2; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d2a_vld && d2b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ca  <= ta[19:5];
            r_cb  <= tb[19:5];
            r_cc  <= tc[19:5];
            r_sec <= sec_f;
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.cmp_a  = r_ca;
    assign o_out.cmp_b  = r_cb;
    assign o_out.cmp_c  = r_cc;
    assign o_out.sector = r_sec;
endmodule

// File: sv/svpwm_from_torque_voltage.sv
// ----------------------------------------------------------------------------
// svpwm_from_torque_voltage
// Seven-segment space vector PWM compare values from Uq and electrical angle.
// ----------------------------------------------------------------------------
// Takes one (uq, angle) transaction per clock when the output is not stalled
// and returns one set of three compare values plus the sector per
// transaction, in order. The path holds 52 register stages: one stage for
// the sine/cosine table read, one in the queue, seven arithmetic stages, two
// 20-stage pipelined dividers (dwell time and proportional rescale), two
// stages around the rescale and the output register. The back pipeline
// stalls as a whole on output back-pressure while the queue keeps absorbing
// input until it is full. Write supply_voltage and pwm_period only while no
// transaction is in flight.
module svpwm_from_torque_voltage #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    svpwm_in_if.sink                         i_in,
    svpwm_out_if.source                      o_out
);
    import svpwm_pkg::*;

    logic [15:0] r_supply;
    logic [15:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SUPPLY: r_supply <= i_cfg_data;
                REG_PERIOD: r_period <= i_cfg_data;
                default:    r_period <= r_period;
            endcase
        end
    end

    svpwm_mid_if u_f2q ();
    svpwm_mid_if u_q2b ();

    svpwm_front #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_supply(r_supply),
        .i_in    (i_in),
        .o_mid   (u_f2q.source)
    );

    svpwm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mid  (u_f2q.sink),
        .o_mid  (u_q2b.source)
    );

    svpwm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_supply(r_supply),
        .i_period(r_period),
        .i_mid   (u_q2b.sink),
        .o_out   (o_out)
    );
endmodule

// File: tb/tb_svpwm_from_torque_voltage.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_svpwm_from_torque_voltage
// Self-checking bench for the space vector PWM compare value pipeline.
// ----------------------------------------------------------------------------
// Drives (uq, angle) transactions and computes the expected phase compare
// values and sector for each one in a bit-accurate predictor of its own.
// Results are checked in order against the queue of expected compares. Runs
// directed corner cases, several supply/period settings including their
// extremes, a long output hold-off and random phases with idling on both
// sides, the last of which runs without idling.
// ----------------------------------------------------------------------------
module tb_svpwm_from_torque_voltage;
    import svpwm_pkg::*;

    typedef struct packed {
        logic [14:0] cmp_a;
        logic [14:0] cmp_b;
        logic [14:0] cmp_c;
        logic [2:0]  sector;
    } t_compare;

    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    svpwm_in_if  in_ch ();
    svpwm_out_if out_ch ();

    svpwm_from_torque_voltage u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    t_compare    compare_q[$];
    logic [15:0] supply_mv;
    logic [15:0] period_ticks;
    int          error_cnt;
    int          sent_cnt;
    int          checked_cnt;
    int          hold_off_cycles;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL svpwm_from_torque_voltage");
        $finish;
    end

    // Q15 sine of a Q32 turn fraction, odd polynomial on the quadrant
    function automatic longint sine_of_turn(longint unsigned turn);
        longint unsigned quad, frac, u, u2, p, s;
        turn = turn & 64'hFFFF_FFFF;
        quad = (turn >> 30) & 3;
        frac = turn & 64'h3FFF_FFFF;
        u    = quad[0] ? (64'd1073741824 - frac) : frac;
        u2   = (u * u) >> 30;
        p    = K7 - ((u2 * K9) >> 30);
        p    = K5 - ((u2 * p) >> 30);
        p    = K3 - ((u2 * p) >> 30);
        p    = K1 - ((u2 * p) >> 30);
        s    = (u * p) >> 30;
        s    = (s + 16384) >> 15;
        if (s > 32768) s = 32768;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint dwell_time(longint w, longint per, longint vs);
        return ((w / 64'sd8388608) * 64'sd113512 * per) / (vs * 64'sd2097152);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_compare predict_compare(logic signed [15:0] uq_in,
                                                 logic [15:0] angle_in);
        longint   uq, half, vs, per, idx, turn, sn, cs, a, b;
        longint   w1, w2, w3, x, y, z, t1, t2, sum, t0h, v1, v2, v3, ta, tb, tc;
        logic [2:0] signs;
        t_compare res;
        half  = longint'(supply_mv >> 1);
        vs    = (supply_mv == 0) ? 1 : longint'(supply_mv);
        per   = longint'(period_ticks) * 16;
        uq    = clip(longint'(uq_in), -half, half);
        idx   = (longint'(angle_in) * 1024) >> 16;
        turn  = idx << 22;
        sn    = sine_of_turn(turn);
        cs    = sine_of_turn(turn + 64'd1073741824);
        a     = 64'sd113512 * (-uq * sn);
        b     = (uq * cs) * 65536;
        w1    = 2 * b;
        w2    = a - b;
        w3    = -(a + b);
        signs = {w3 > 0, w2 > 0, w1 > 0};
        res.sector = SIGN_TO_SECTOR[signs];
        x = dwell_time(w1, longint'(period_ticks), vs);
        y = dwell_time(w2, longint'(period_ticks), vs);
        z = dwell_time(w3, longint'(period_ticks), vs);
        case (res.sector)
            SECTOR_1: begin t1 = y;  t2 = x;  end
            SECTOR_2: begin t1 = -y; t2 = -z; end
            SECTOR_3: begin t1 = x;  t2 = z;  end
            SECTOR_4: begin t1 = -x; t2 = -y; end
            SECTOR_5: begin t1 = z;  t2 = y;  end
            default:  begin t1 = -z; t2 = -x; end
        endcase
        t1  = clip(t1, 0, per);
        t2  = clip(t2, 0, per);
        sum = t1 + t2;
        if (sum > per) begin
            t1 = (t1 * per) / sum;
            t2 = (t2 * per) / sum;
        end
        t0h = (per - t1 - t2) / 2;
        v1  = t1 + t2 + t0h;
        v2  = t2 + t0h;
        v3  = t0h;
        case (res.sector)
            SECTOR_1: begin ta = v1; tb = v2; tc = v3; end
            SECTOR_2: begin ta = v2; tb = v1; tc = v3; end
            SECTOR_3: begin ta = v3; tb = v1; tc = v2; end
            SECTOR_4: begin ta = v3; tb = v2; tc = v1; end
            SECTOR_5: begin ta = v2; tb = v3; tc = v1; end
            default:  begin ta = v1; tb = v3; tc = v2; end
        endcase
        res.cmp_a = 15'(clip(ta, 0, per) >> 5);
        res.cmp_b = 15'(clip(tb, 0, per) >> 5);
        res.cmp_c = 15'(clip(tc, 0, per) >> 5);
        return res;
    endfunction

    // Result side: check accepted transactions, then pick next ready
    initial begin
        int stall_left;
        t_compare want;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                checked_cnt++;
                if (compare_q.size() == 0) begin
                    $error("result with no expectation: a=%0d b=%0d c=%0d sector=%0d",
                           out_ch.cmp_a, out_ch.cmp_b, out_ch.cmp_c, out_ch.sector);
                    error_cnt++;
                end else begin
                    want = compare_q.pop_front();
                    if (out_ch.cmp_a !== want.cmp_a) begin
                        $error("cmp_a expected %0d actual %0d", want.cmp_a, out_ch.cmp_a);
                        error_cnt++;
                    end
                    if (out_ch.cmp_b !== want.cmp_b) begin
                        $error("cmp_b expected %0d actual %0d", want.cmp_b, out_ch.cmp_b);
                        error_cnt++;
                    end
                    if (out_ch.cmp_c !== want.cmp_c) begin
                        $error("cmp_c expected %0d actual %0d", want.cmp_c, out_ch.cmp_c);
                        error_cnt++;
                    end
                    if (out_ch.sector !== want.sector) begin
                        $error("sector expected %0d actual %0d", want.sector,
                               out_ch.sector);
                        error_cnt++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send_command(logic signed [15:0] uq, logic [15:0] angle);
        in_ch.valid <= 1'b1;
        in_ch.uq    <= uq;
        in_ch.angle <= angle;
        do @(posedge i_clk); while (!in_ch.ready);
        compare_q.push_back(predict_compare(uq, angle));
        sent_cnt++;
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (compare_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == REG_SUPPLY) supply_mv = value;
        else period_ticks = value;
    endtask

    task automatic set_config(logic [15:0] vs, logic [15:0] per);
        write_reg(REG_SUPPLY, vs);
        write_reg(REG_PERIOD, per);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] random_uq();
        int half;
        half = supply_mv >> 1;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(half + $urandom_range(0, 4) - 2);
            2: return 16'(-half + $urandom_range(0, 4) - 2);
            default: return 16'($urandom_range(0, 2 * half) - half);
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) begin
            send_command(random_uq(), 16'($urandom));
            maybe_gap();
        end
    endtask

    task automatic test_directed();
        logic signed [15:0] uqs [4] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd4000};
        logic [15:0] angs [5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
        foreach (uqs[i]) foreach (angs[j]) send_command(uqs[i], angs[j]);
        // six angles a sixth of a turn apart, offset by a twelfth of a turn
        for (int k = 0; k < 6; k++) send_command(16'sd5000, 16'(k * 10923 + 5461));
        drain();
    endtask

    task automatic test_config_extremes();
        logic [15:0] vs_set  [6] = '{16'd1, 16'd65535, 16'd12001, 16'd7, 16'd65535, 16'd2};
        logic [15:0] per_set [6] = '{16'd2, 16'd65535, 16'd3, 16'd65535, 16'd2, 16'd4800};
        foreach (vs_set[i]) begin
            set_config(vs_set[i], per_set[i]);
            send_command(16'sd32767, 16'd8000);
            send_command(-16'sd32768, 16'd40000);
            send_random(18);
            drain();
        end
    endtask

    task automatic test_backpressure();
        set_config(16'd24000, 16'd9000);
        hold_off_cycles = 300;
        repeat (120) send_command(random_uq(), 16'($urandom));
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) quiet = 1'b1;
            if ($urandom_range(0, 1)) set_config(16'($urandom_range(1, 65535)),
                                                 16'($urandom_range(2, 65535)));
            else set_config(16'($urandom_range(1, 40000)), 16'($urandom_range(2, 6000)));
            send_random(72);
            drain();
        end
    endtask

    initial begin
        error_cnt       = 0;
        sent_cnt        = 0;
        checked_cnt     = 0;
        hold_off_cycles = 0;
        quiet           = 1'b0;
        supply_mv       = SUPPLY_RESET;
        period_ticks    = PERIOD_RESET;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.uq        = '0;
        in_ch.angle     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        $display("Covered %0d transactions, %0d results checked, over corner,",
                 sent_cnt, checked_cnt);
        $display("extreme-setting, long hold-off and random phases.");
        if (error_cnt == 0 && compare_q.size() == 0) begin
            $display("PASS svpwm_from_torque_voltage");
        end else begin
            if (compare_q.size() != 0)
                $error("%0d expected results never arrived", compare_q.size());
            $display("FAIL svpwm_from_torque_voltage");
        end
        $finish;
    end

endmodule

// File: files.f
sv/svpwm_pkg.sv
sv/svpwm_if.sv
sv/svpwm_div.sv
sv/svpwm_front.sv
sv/svpwm_queue.sv
sv/svpwm_back.sv
sv/svpwm_from_torque_voltage.sv
tb/tb_svpwm_from_torque_voltage.sv
